### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while the disable term is high.
`define AST_IMP(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while the disable term is high.
`define AST_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/wbg_pkg.sv
// Package of types, codes and wave tables for the wavetable beep generator.
`timescale 1ns / 1ps

package wbg_pkg;

    // Command codes carried on the input tuser bit.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_BEEP = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WAVE_SEL  = 2'd0;
    localparam logic [1:0] CFG_CUSTOM_LO = 2'd1;
    localparam logic [1:0] CFG_CUSTOM_HI = 2'd2;

    // Wave selector codes; the unused codes read the custom table.
    localparam logic [2:0] WAVE_CUSTOM   = 3'd0;
    localparam logic [2:0] WAVE_SQUARE   = 3'd1;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [2:0] WAVE_SAWTOOTH = 3'd3;
    localparam logic [2:0] WAVE_SINE     = 3'd4;
    localparam logic [2:0] WAVE_ORGAN    = 3'd5;

    // Field widths.
    localparam int FREQ_W  = 19;
    localparam int LEN_W   = 24;
    localparam int PHASE_W = 24;
    localparam int VOL_W   = 17;
    localparam int IDX_W   = 4;

    // Volume of exactly one in 1.16 format.
    localparam logic [VOL_W-1:0] VOL_ONE = 17'h10000;

    // Queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // One classified word as it travels through the queue.
    typedef struct packed {
        logic               cmd;
        logic [PHASE_W-1:0] step;
        logic [LEN_W-1:0]   len;
    } t_item;

    // Occupancy of the front pipeline stages.
    typedef struct packed {
        logic a_valid;
        logic b_valid;
    } t_front_occ;

    // Preset wave tables: square, triangle, sawtooth, sine, organ.
    localparam logic [7:0] WAVE_ROM [0:4][0:15] = '{
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h20, 8'h40, 8'h60, 8'h80, 8'hA0, 8'hC0, 8'hE0, 8'hFF,
          8'hE0, 8'hC0, 8'hA0, 8'h80, 8'h60, 8'h40, 8'h20, 8'h00},
        '{8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'h70, 8'h80,
          8'h90, 8'hA0, 8'hB0, 8'hC0, 8'hD0, 8'hE0, 8'hF0, 8'hFF},
        '{8'hB0, 8'hD9, 8'hF5, 8'hFF, 8'hF5, 8'hD9, 8'hB0, 8'h7F,
          8'h4E, 8'h25, 8'h09, 8'h00, 8'h09, 8'h25, 8'h4E, 8'h7F},
        '{8'hFF, 8'hC0, 8'hC0, 8'h80, 8'hC0, 8'h80, 8'h80, 8'h40,
          8'hC0, 8'h80, 8'h80, 8'h40, 8'h80, 8'h40, 8'h40, 8'h00}
    };

    // Table entry for a selector, falling back to the custom table.
    function automatic logic [7:0] wave_entry(input logic [2:0]       sel,
                                              input logic [IDX_W-1:0] idx,
                                              input logic [127:0]     custom);
        logic [2:0] row;
        row = sel - WAVE_SQUARE;
        if (sel >= WAVE_SQUARE && sel <= WAVE_ORGAN) begin
            return WAVE_ROM[row][idx];
        end
        return custom[{idx, 3'b000} +: 8];
    endfunction

endpackage

### rtl/core/wbg_front.sv
// Front of the beep generator: turns each word's frequency into a phase step.
`timescale 1ns / 1ps

module wbg_front #(
    parameter int SAMPLE_RATE = 44100
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_cmd,
    input  logic [wbg_pkg::FREQ_W-1:0]  i_freq,
    input  logic [wbg_pkg::LEN_W-1:0]   i_len,
    output logic                        o_valid,
    output wbg_pkg::t_item              o_item,
    output wbg_pkg::t_front_occ         o_occ
);
    import wbg_pkg::*;

    // The step is floor(freq * 2^20 / SAMPLE_RATE). A reciprocal with
    // SHIFT_K extra bits gives a quotient that is at most one too small.
    localparam int          FRAC_W  = 20;
    localparam int          SHIFT_K = FREQ_W;
    localparam logic [63:0] RECIP   = (64'd1 << (FRAC_W + SHIFT_K)) / SAMPLE_RATE;
    localparam int          MW      = $clog2(RECIP + 64'd1);
    localparam int          SRW     = $clog2(SAMPLE_RATE + 1);
    localparam int          PW      = FREQ_W + MW;
    localparam int          DW      = MW + SRW + 1;
    localparam logic [MW-1:0]  RECIP_C = MW'(RECIP);
    localparam logic [SRW-1:0] RATE_C  = SRW'(SAMPLE_RATE);

    // Stage A: frequency times the reciprocal.
    logic                r_a_valid;
    logic                r_a_cmd;
    logic [FREQ_W-1:0]   r_a_freq;
    logic [LEN_W-1:0]    r_a_len;
    logic [PW-1:0]       r_a_prod;

    // Stage B: estimated quotient and its product with the rate.
    logic                r_b_valid;
    logic                r_b_cmd;
    logic [FREQ_W-1:0]   r_b_freq;
    logic [LEN_W-1:0]    r_b_len;
    logic [MW-1:0]       r_b_q;
    logic [MW+SRW-1:0]   r_b_qsr;

    logic [MW-1:0]       a_q;
    logic [DW-1:0]       b_rem;
    logic [MW:0]         b_q_fix;

    assign a_q = r_a_prod[PW-1:SHIFT_K];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
        r_a_cmd  <= i_cmd;
        r_a_freq <= i_freq;
        r_a_len  <= i_len;
        r_a_prod <= PW'(i_freq) * PW'(RECIP_C);
        r_b_cmd  <= r_a_cmd;
        r_b_freq <= r_a_freq;
        r_b_len  <= r_a_len;
        r_b_q    <= a_q;
        r_b_qsr  <= (MW+SRW)'(a_q) * (MW+SRW)'(RATE_C);
    end

    // Remainder check lifts the estimate by one where it fell short.
    always_comb begin
        b_rem   = DW'({r_b_freq, {FRAC_W{1'b0}}}) - DW'(r_b_qsr);
        b_q_fix = {1'b0, r_b_q} + ((b_rem >= DW'(RATE_C)) ? (MW+1)'(1) : (MW+1)'(0));
    end

    assign o_valid       = r_b_valid;
    assign o_item.cmd    = r_b_cmd;
    assign o_item.step   = PHASE_W'(b_q_fix);
    assign o_item.len    = r_b_len;
    assign o_occ.a_valid = r_a_valid;
    assign o_occ.b_valid = r_b_valid;

endmodule

### rtl/core/wbg_queue.sv
// Short first-in first-out queue of classified words between front and back.
`timescale 1ns / 1ps

module wbg_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  wbg_pkg::t_item              i_item,
    input  logic                        i_pop,
    output logic                        o_valid,
    output wbg_pkg::t_item              o_item,
    output logic [wbg_pkg::QCNT_W-1:0]  o_count
);
    import wbg_pkg::*;

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    // Pointers and fill count; the front never pushes into a full queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

### rtl/core/wbg_back.sv
// Back of the beep generator: envelope, wave lookup, phase and output word.
`timescale 1ns / 1ps

module wbg_back #(
    parameter int ENV_SAMPLES = 512
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  wbg_pkg::t_item  i_item,
    output logic            o_pop,
    input  logic [2:0]      i_wave_sel,
    input  logic [127:0]    i_custom,
    output logic            o_m_valid,
    input  logic            i_m_ready,
    output logic [7:0]      o_sample,
    output logic            o_sounding
);
    import wbg_pkg::*;

    localparam int               ENV_DIV  = 65536 / ENV_SAMPLES;
    localparam logic [VOL_W-1:0] ENV_STEP = VOL_W'((ENV_DIV == 0) ? 1 : ENV_DIV);
    localparam logic [LEN_W-1:0] ENV_LIM  = LEN_W'(ENV_SAMPLES);

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] r_step;
    logic [LEN_W-1:0]   r_left;
    logic [VOL_W-1:0]   r_vol;
    logic               r_m_valid;
    logic [7:0]         r_sample;
    logic               r_sounding;

    logic               tick;
    logic               beep;
    logic [VOL_W:0]     vol_sum;
    logic [VOL_W-1:0]   n_vol;
    logic [7:0]         entry;
    logic [VOL_W+7:0]   scaled;

    // A beep word never waits for the output; a tick needs a free slot.
    assign beep  = i_valid && (i_item.cmd == CMD_BEEP);
    assign tick  = i_valid && (i_item.cmd == CMD_TICK) && (!r_m_valid || i_m_ready);
    assign o_pop = beep || tick;

    // Envelope ramps up while the beep is long enough, down otherwise.
    always_comb begin
        vol_sum = {1'b0, r_vol} + {1'b0, ENV_STEP};
        if (r_left > ENV_LIM) begin
            n_vol = (vol_sum >= {1'b0, VOL_ONE}) ? VOL_ONE : vol_sum[VOL_W-1:0];
        end else begin
            n_vol = (r_vol <= ENV_STEP) ? '0 : r_vol - ENV_STEP;
        end
        entry  = wave_entry(i_wave_sel, r_phase[PHASE_W-1 -: IDX_W], i_custom);
        scaled = (VOL_W+8)'(n_vol) * (VOL_W+8)'(entry);
    end

    // Generator state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_step    <= '0;
            r_left    <= '0;
            r_vol     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (beep) begin
                r_step <= i_item.step;
                r_left <= i_item.len;
            end else if (tick) begin
                r_vol   <= n_vol;
                r_phase <= r_phase + r_step;
                if (r_left != '0) begin
                    r_left <= r_left - LEN_W'(1);
                end
            end
            if (tick) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (tick) begin
            // Volume never exceeds one, so the product stays within a byte.
            r_sample   <= scaled[16 +: 8];
            r_sounding <= (r_left != '0) || (n_vol != '0);
        end
    end

    assign o_m_valid  = r_m_valid;
    assign o_sample   = r_sample;
    assign o_sounding = r_sounding;

endmodule

### rtl/core/wavetable_beep_generator.sv
// Wavetable beep generator with linear envelope, top level.
// Words enter on the s_ stream: tuser 0 is a tick that yields one sample word on
// the m_ stream, tuser 1 starts a beep and yields nothing. One word is taken in
// every clock cycle while s_tready is high; a tick's result passes through two
// multiplier stages that turn the frequency into a phase step, a four-entry
// queue, then the output register. The input stalls only when the queue plus
// the multiplier stages hold four words, which happens when the output side
// holds back. Configuration writes take effect at once; the user must make them
// while the block is idle, and the block itself does not enforce it.
`timescale 1ns / 1ps

module wavetable_beep_generator #(
    parameter int SAMPLE_RATE = 44100,
    parameter int ENV_SAMPLES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // tone_freq [18:0], beep_length [42:19], zeros
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample [7:0], sounding [8], zeros
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import wbg_pkg::*;

    logic [2:0]        r_wave_sel;
    logic [63:0]       r_custom_lo;
    logic [63:0]       r_custom_hi;

    logic              accept;
    logic              f_valid;
    t_item             f_item;
    t_front_occ        f_occ;
    logic              q_valid;
    t_item             q_item;
    logic [QCNT_W-1:0] q_count;
    logic [QCNT_W-1:0] occupancy;
    logic              pop;
    logic [7:0]        sample;
    logic              sounding;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_sel  <= WAVE_CUSTOM;
            r_custom_lo <= '0;
            r_custom_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WAVE_SEL:  r_wave_sel  <= i_cfg_data[2:0];
                CFG_CUSTOM_LO: r_custom_lo <= i_cfg_data;
                CFG_CUSTOM_HI: r_custom_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Credit check: words in flight plus queued words must leave room.
    assign occupancy = q_count + QCNT_W'(f_occ.a_valid) + QCNT_W'(f_occ.b_valid);
    assign s_tready  = (occupancy < QCNT_W'(QDEPTH));
    assign accept    = s_tvalid && s_tready;

    wbg_front #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_cmd   (s_tuser),
        .i_freq  (s_tdata[FREQ_W-1:0]),
        .i_len   (s_tdata[FREQ_W +: LEN_W]),
        .o_valid (f_valid),
        .o_item  (f_item),
        .o_occ   (f_occ)
    );

    wbg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_count (q_count)
    );

    wbg_back #(
        .ENV_SAMPLES (ENV_SAMPLES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_item     (q_item),
        .o_pop      (pop),
        .i_wave_sel (r_wave_sel),
        .i_custom   ({r_custom_hi, r_custom_lo}),
        .o_m_valid  (m_tvalid),
        .i_m_ready  (m_tready),
        .o_sample   (sample),
        .o_sounding (sounding)
    );

    assign m_tdata = {7'b0, sounding, sample};

endmodule

### rtl/core/wbg_checker.sv
// Port-level checker for the wavetable beep generator and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wbg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A held output word keeps its contents.
    `AST_NEXT(a_out_hold, i_clk, !i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

    // A silent word carries a zero sample.
    `AST_IMP(a_silent_zero, i_clk, !i_rst_n, m_tvalid && !m_tdata[8], m_tdata[7:0] == 8'd0, "silent word with nonzero sample")

    // Padding bits of the output word stay clear.
    `AST_IMP(a_pad_zero, i_clk, !i_rst_n, m_tvalid, m_tdata[15:9] == 7'd0, "output padding not zero")

    // Reset empties the block: no output and room for input straight after.
    `AST_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !m_tvalid && s_tready, "block not empty after reset")

endmodule

bind wavetable_beep_generator wbg_checker u_wbg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/tb_wavetable_beep_generator.sv
// Self-checking testbench for the wavetable beep generator: reset, directed, envelope and random tests.
`timescale 1ns / 1ps

module tb_wavetable_beep_generator;

    import wbg_pkg::*;

    // Block parameters as instantiated, and testbench timing.
    localparam int          SAMPLE_RATE_HZ = 44100;
    localparam int          ENV_LEN        = 512;
    localparam int          ENV_STEP       = (65536 / ENV_LEN == 0) ? 1 : 65536 / ENV_LEN;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          IDLE_PERCENT   = 23;
    localparam logic [1:0]  CFG_UNUSED     = 2'd3;

    // Preset tables, entry 0 in the lowest byte.
    localparam logic [127:0] SQUARE_BITS   = 128'h0000000000000000_FFFFFFFFFFFFFFFF;
    localparam logic [127:0] TRIANGLE_BITS = 128'h0020406080A0C0E0_FFE0C0A080604020;
    localparam logic [127:0] SAWTOOTH_BITS = 128'hFFF0E0D0C0B0A090_8070605040302010;
    localparam logic [127:0] SINE_BITS     = 128'h7F4E25090009254E_7FB0D9F5FFF5D9B0;
    localparam logic [127:0] ORGAN_BITS    = 128'h00404080408080C0_408080C080C0C0FF;

    // One sample word as it leaves the block.
    typedef struct packed {
        logic [7:0] level;
        logic       sounding;
    } t_tone_word;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata    = '0;
    logic        s_tuser    = 1'b0;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [15:0] m_tdata;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = '0;
    logic [63:0] i_cfg_data = '0;

    // Predicted oscillator state and register copies.
    logic [23:0]  osc_phase;
    logic [23:0]  osc_step;
    logic [23:0]  beep_left;
    int unsigned  env_level;
    logic [2:0]   sel_wave;
    logic [127:0] custom_bits;

    t_tone_word   expected_samples [$];
    int           fail_count   = 0;
    int           words_sent   = 0;
    int           stall_cycles = 0;
    bit           steady_flow  = 1'b0;

    wavetable_beep_generator #(
        .SAMPLE_RATE (SAMPLE_RATE_HZ),
        .ENV_SAMPLES (ENV_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver holds back at random unless a steady stretch is running.
    always @(posedge i_clk) begin
        m_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Table entry the oscillator reads for the current selector.
    function automatic logic [7:0] wave_level(input logic [3:0] idx);
        logic [127:0] bits;
        case (sel_wave)
            WAVE_SQUARE:   bits = SQUARE_BITS;
            WAVE_TRIANGLE: bits = TRIANGLE_BITS;
            WAVE_SAWTOOTH: bits = SAWTOOTH_BITS;
            WAVE_SINE:     bits = SINE_BITS;
            WAVE_ORGAN:    bits = ORGAN_BITS;
            default:       bits = custom_bits;
        endcase
        return bits[{idx, 3'b000} +: 8];
    endfunction

    // Advances the predicted oscillator by one accepted word.
    task automatic predict_word(input logic cmd, input logic [18:0] freq,
                                input logic [23:0] len);
        logic [63:0] scaled;
        int unsigned product;
        t_tone_word  want;
        if (cmd == CMD_BEEP) begin
            scaled    = {45'd0, freq} << 20;
            scaled    = scaled / 64'(SAMPLE_RATE_HZ);
            osc_step  = scaled[23:0];
            beep_left = len;
        end else begin
            // Envelope first: rise while the beep is long, fall otherwise.
            if (beep_left > 24'(ENV_LEN)) begin
                env_level = (env_level + ENV_STEP >= 65536) ? 65536 : env_level + ENV_STEP;
            end else begin
                env_level = (env_level <= ENV_STEP) ? 0 : env_level - ENV_STEP;
            end
            product       = env_level * 32'(wave_level(osc_phase[23:20]));
            product       = product >> 16;
            want.level    = (product > 255) ? 8'hFF : product[7:0];
            want.sounding = (beep_left != 0) || (env_level != 0);
            expected_samples.push_back(want);
            osc_phase = osc_phase + osc_step;
            if (beep_left != 0) begin
                beep_left = beep_left - 24'd1;
            end
        end
    endtask

    // Sends one word with random gaps in front, then predicts its effect.
    task automatic send_word(input logic cmd, input logic [18:0] freq,
                             input logic [23:0] len);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, len, freq};
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        words_sent++;
        predict_word(cmd, freq, len);
    endtask

    task automatic send_tick();
        send_word(CMD_TICK, 19'($urandom), 24'($urandom));
    endtask

    // Holds the sender until every expected sample is back and the block is quiet.
    task automatic wait_for_quiet();
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register; only called while the block is quiet.
    task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WAVE_SEL:  sel_wave = value[2:0];
            CFG_CUSTOM_LO: custom_bits[63:0] = value;
            CFG_CUSTOM_HI: custom_bits[127:64] = value;
            default: ;
        endcase
    endtask

    // Ticks straight after reset: empty custom table, nothing sounding.
    task automatic test_reset_state();
        send_tick();
        send_tick();
    endtask

    // Field extremes and envelope boundaries on the sawtooth.
    task automatic test_directed();
        write_register(CFG_WAVE_SEL, 64'(WAVE_SAWTOOTH));
        send_word(CMD_BEEP, 19'd0, 24'd0);
        send_tick();
        send_word(CMD_BEEP, 19'h7FFFF, 24'hFFFFFF);
        repeat (3) send_tick();
        send_word(CMD_BEEP, 19'd352800, 24'd513);
        repeat (2) send_tick();
        send_word(CMD_BEEP, 19'd7040, 24'd512);
        repeat (2) send_tick();
        // A second beep replaces the first before any tick.
        send_word(CMD_BEEP, 19'd1, 24'd1);
        send_word(CMD_BEEP, 19'd100000, 24'd2);
        repeat (3) send_tick();
        wait_for_quiet();
    endtask

    // Full attack to a volume of one, a short sustain, then the start of the release.
    task automatic test_envelope();
        write_register(CFG_WAVE_SEL, 64'(WAVE_SINE));
        send_word(CMD_BEEP, 19'd16000, 24'd1030);
        repeat (520) send_tick();
        send_word(CMD_BEEP, 19'd8000, 24'd0);
        repeat (30) send_tick();
        wait_for_quiet();
    endtask

    // A beep of random shape followed by a run of ticks, or a burst of noise.
    task automatic play_random_phrase();
        int          pick;
        int          ticks;
        logic [18:0] freq;
        logic [23:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            repeat ($urandom_range(1, 4)) begin
                send_word(1'($urandom), 19'($urandom), 24'($urandom));
            end
        end else begin
            freq = ($urandom_range(0, 99) < 70) ? 19'($urandom_range(0, 352800))
                                                : 19'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45)      len = 24'($urandom_range(513, 4000));
            else if (pick < 65) len = 24'($urandom_range(500, 530));
            else if (pick < 80) len = 24'($urandom_range(0, 40));
            else if (pick < 90) len = 24'($urandom);
            else                len = 24'd0;
            send_word(CMD_BEEP, freq, len);
            ticks = $urandom_range(0, 30);
            repeat (ticks) send_tick();
        end
    endtask

    // Random phrases under every wave selector, with fresh custom tables.
    task automatic test_random_phases();
        int          start;
        logic [63:0] lo_bits;
        logic [63:0] hi_bits;
        for (int p = 0; p < 8; p++) begin
            wait_for_quiet();
            if (p == 0) begin
                lo_bits = '1;
                hi_bits = '1;
            end else if (p == 7) begin
                lo_bits = '0;
                hi_bits = '1;
            end else begin
                lo_bits = {$urandom, $urandom};
                hi_bits = {$urandom, $urandom};
            end
            write_register(CFG_CUSTOM_LO, lo_bits);
            write_register(CFG_CUSTOM_HI, hi_bits);
            write_register(CFG_WAVE_SEL, 64'(p));
            // Writes to the spare index must leave everything alone.
            if (p == 5) begin
                write_register(CFG_UNUSED, {$urandom, $urandom});
            end
            // The steady stretch runs longer than the other phases.
            steady_flow = (p == 3);
            start = words_sent;
            while (words_sent - start < ((p == 3) ? 100 : 20)) begin
                play_random_phrase();
            end
            steady_flow = 1'b0;
        end
        wait_for_quiet();
    endtask

    // Compares each sample word with the oldest prediction.
    always @(posedge i_clk) begin : check_samples
        t_tone_word want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected sample word, expected none, actual %h",
                         $time, m_tdata);
                fail_count++;
            end else begin
                want = expected_samples.pop_front();
                if (m_tdata[7:0] !== want.level) begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, want.level, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[8] !== want.sounding) begin
                    $display("%0t: sounding mismatch, expected %0d, actual %0d",
                             $time, want.sounding, m_tdata[8]);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run if neither side moves a word for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Test sequence.
    initial begin
        osc_phase   = '0;
        osc_step    = '0;
        beep_left   = '0;
        env_level   = 0;
        sel_wave    = WAVE_CUSTOM;
        custom_bits = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        wait_for_quiet();
        test_directed();
        test_envelope();
        test_random_phases();
        if (fail_count == 0 && expected_samples.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
